### sv/lfk_pkg.sv
`timescale 1ns / 1ps

package lfk_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_ABAD = 2'd0,
    REG_HIP  = 2'd1,
    REG_KNEE = 2'd2
  } cfg_reg_e;

  // Cartesian row of a result.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Depth of the sine and cosine pipeline, in register stages.
  localparam int SC_LAT = 19;

  // Sine and cosine in Q30, both signed.
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } trig_t;

endpackage

### sv/lfk_sincos.sv
`timescale 1ns / 1ps

module lfk_sincos import lfk_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] angle_i,
  output trig_t              trig_o
);

  localparam logic [34:0] HALF_PI     = 35'd1686629713;
  localparam logic [34:0] HALF_PI_RND = 35'd843314856;
  localparam int          KMAX        = 5;
  localparam int          SIN_STEPS   = 4;
  localparam int          COS_STEPS   = 5;
  localparam int          SUB         = 3 * COS_STEPS;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam logic [6:0] DIV_SIN [SIN_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] DIV_COS [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] RCP_SIN [SIN_STEPS] = '{
    32'(64'h1_0000_0000 / 64'd72), 32'(64'h1_0000_0000 / 64'd42),
    32'(64'h1_0000_0000 / 64'd20), 32'(64'h1_0000_0000 / 64'd6)};
  localparam logic [31:0] RCP_COS [COS_STEPS] = '{
    32'(64'h1_0000_0000 / 64'd90), 32'(64'h1_0000_0000 / 64'd56),
    32'(64'h1_0000_0000 / 64'd30), 32'(64'h1_0000_0000 / 64'd12),
    32'(64'h1_0000_0000 / 64'd2)};

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic        rneg;
    logic [1:0]  quad;
    logic        neg;
  } side_t;

  // Q30 product, truncated.
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] prod;
    prod = 62'(a) * 62'(b);
    return prod[60:30];
  endfunction

  // Quotient estimate from a reciprocal; low by at most one.
  function automatic logic [30:0] recip_est(input logic [30:0] p, input logic [31:0] m);
    logic [62:0] prod;
    prod = 63'(p) * 63'(m);
    return prod[62:32];
  endfunction

  function automatic logic [30:0] div_fix(input logic [30:0] p, input logic [30:0] e,
                                          input logic [6:0] d);
    logic [37:0] ed;
    logic [30:0] rem;
    ed  = 38'(e) * 38'(d);
    rem = p - 31'(ed);
    return (rem >= 31'(d)) ? e + 31'd1 : e;
  endfunction

  // Range reduction: magnitude in Q30 and nearest quarter turn.
  logic [16:0] mag;
  logic [33:0] m_d, m_q;
  logic [2:0]  k_d, k_q;
  logic        neg1_q;

  always_comb begin
    mag = angle_i[16] ? 17'(-angle_i) : 17'(angle_i);
    m_d = {mag, 17'd0};
    k_d = '0;
    for (int j = 1; j <= KMAX; j++) begin
      if ({1'b0, m_d} + HALF_PI_RND >= 35'(j) * HALF_PI) begin
        k_d = k_d + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      k_q    <= k_d;
      neg1_q <= angle_i[16];
    end
  end

  // Remainder within a quarter turn of zero.
  logic [34:0]        kh;
  logic signed [35:0] r;
  logic [29:0]        x_d, x_q;
  logic               rneg_q, neg2_q;
  logic [1:0]         quad_q;

  always_comb begin
    kh  = 35'(k_q) * HALF_PI;
    r   = $signed({2'b00, m_q}) - $signed({1'b0, kh});
    x_d = r[35] ? 30'(-r) : 30'(r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      rneg_q <= r[35];
      quad_q <= k_q[1:0];
      neg2_q <= neg1_q;
    end
  end

  side_t side_q [SUB + 1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{x: x_q, x2: 30'(mul_q30({1'b0, x_q}, {1'b0, x_q})),
                     rneg: rneg_q, quad: quad_q, neg: neg2_q};
      for (int i = 1; i <= SUB; i++) begin
        side_q[i] <= side_q[i - 1];
      end
    end
  end

  // Horner steps: product, reciprocal estimate, then correction and subtract.
  logic [30:0] pa_s_q [COS_STEPS];
  logic [30:0] pb_s_q [COS_STEPS];
  logic [30:0] tc_s_q [COS_STEPS];
  logic [30:0] eb_s_q [SIN_STEPS];
  logic [30:0] pa_c_q [COS_STEPS];
  logic [30:0] pb_c_q [COS_STEPS];
  logic [30:0] eb_c_q [COS_STEPS];
  logic [30:0] tc_c_q [COS_STEPS];

  for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
    logic [30:0] tin_c;

    if (j == 0) begin : g_first
      assign tin_c = Q30_ONE;
    end else begin : g_next
      assign tin_c = tc_c_q[j - 1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_c_q[j] <= mul_q30({1'b0, side_q[3 * j].x2}, tin_c);
        eb_c_q[j] <= recip_est(pa_c_q[j], RCP_COS[j]);
        pb_c_q[j] <= pa_c_q[j];
        tc_c_q[j] <= Q30_ONE - div_fix(pb_c_q[j], eb_c_q[j], DIV_COS[j]);
      end
    end

    if (j < SIN_STEPS) begin : g_sin
      logic [30:0] tin_s;

      if (j == 0) begin : g_first
        assign tin_s = Q30_ONE;
      end else begin : g_next
        assign tin_s = tc_s_q[j - 1];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_s_q[j] <= mul_q30({1'b0, side_q[3 * j].x2}, tin_s);
          eb_s_q[j] <= recip_est(pa_s_q[j], RCP_SIN[j]);
          pb_s_q[j] <= pa_s_q[j];
          tc_s_q[j] <= Q30_ONE - div_fix(pb_s_q[j], eb_s_q[j], DIV_SIN[j]);
        end
      end
    end else begin : g_sin_out
      // The sine series is done; scale it by the remainder and keep it in step.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_s_q[j] <= mul_q30({1'b0, side_q[3 * j].x}, tc_s_q[j - 1]);
          pb_s_q[j] <= pa_s_q[j];
          tc_s_q[j] <= pb_s_q[j];
        end
      end
    end
  end

  // Quadrant and sign restore.
  logic signed [31:0] srs, crs, s_v, c_v;
  trig_t              trig_d, trig_q;

  always_comb begin
    srs = side_q[SUB].rneg ? -$signed({1'b0, tc_s_q[COS_STEPS - 1]})
                           : $signed({1'b0, tc_s_q[COS_STEPS - 1]});
    crs = $signed({1'b0, tc_c_q[COS_STEPS - 1]});
    unique case (side_q[SUB].quad)
      2'd0: begin
        s_v = srs;
        c_v = crs;
      end
      2'd1: begin
        s_v = crs;
        c_v = -srs;
      end
      2'd2: begin
        s_v = -srs;
        c_v = -crs;
      end
      default: begin
        s_v = -crs;
        c_v = srs;
      end
    endcase
    trig_d.s = side_q[SUB].neg ? -s_v : s_v;
    trig_d.c = c_v;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

### sv/leg_forward_kinematics_jacobian.sv
`timescale 1ns / 1ps
// Row x of an item leaves first, rows y and z follow.
// Each item leaves as three rows; new items wait until the output stage is empty or sends its last row.
// The whole pipeline moves on one enable, so a stalled output freezes every stage.
// Reset clears all valid bits and the row counter and loads the default link lengths;
// the datapath registers are not reset.

module leg_forward_kinematics_jacobian import lfk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         leg_index_i,
  input  logic signed [15:0] angle_abad_i,
  input  logic signed [15:0] angle_hip_i,
  input  logic signed [15:0] angle_knee_i,
  input  logic signed [15:0] rate_abad_i,
  input  logic signed [15:0] rate_hip_i,
  input  logic signed [15:0] rate_knee_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         leg_echo_o,
  output logic [1:0]         axis_row_o,
  output logic signed [15:0] foot_position_o,
  output logic signed [23:0] foot_velocity_o,
  output logic signed [15:0] jac_wrt_abad_o,
  output logic signed [15:0] jac_wrt_hip_o,
  output logic signed [15:0] jac_wrt_knee_o,
  output logic               row_last_o
);

  typedef struct packed {
    logic [1:0]       leg;
    logic [2:0][15:0] rate;
  } item_t;

  // Round to nearest with ties away from zero, then shift right by n.
  function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] v, input int n);
    logic signed [79:0] half;
    half = 80'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [79:0] v);
    if (v > 80'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -80'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [79:0] v);
    if (v > 80'sd8388607) begin
      return 24'sh7fffff;
    end
    if (v < -80'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(v);
  endfunction

  // Link length registers. Writes must come only while the block is idle, a rule the
  // user keeps; the block itself has no check for it, and the datapath reads them directly.
  logic [14:0] abad_q, hip_q, knee_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abad_q <= 15'd2032;
      hip_q  <= 15'd6849;
      knee_q <= 15'd6390;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ABAD: abad_q <= cfg_data_i;
        REG_HIP:  hip_q  <= cfg_data_i;
        REG_KNEE: knee_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One enable for every stage: the pipeline moves when the output stage is
  // empty or is handing over its last row.
  logic  adv;
  logic  out_v_q;
  axis_e row_q;

  assign adv        = !out_v_q || (!out_stall_i && row_q == AXIS_Z);
  assign in_stall_o = !adv;

  // Valid bits of every stage.
  logic in_v_q;
  logic vd_q [SC_LAT];
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      vd_q    <= '{default: 1'b0};
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_valid_i;
      vd_q[0] <= in_v_q;
      for (int i = 1; i < SC_LAT; i++) begin
        vd_q[i] <= vd_q[i - 1];
      end
      v1_q    <= vd_q[SC_LAT - 1];
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      out_v_q <= v5_q;
    end
  end

  // Row counter of the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= AXIS_X;
    end else if (adv) begin
      row_q <= AXIS_X;
    end else if (out_v_q && !out_stall_i) begin
      unique case (row_q)
        AXIS_X:  row_q <= AXIS_Y;
        AXIS_Y:  row_q <= AXIS_Z;
        default: row_q <= AXIS_X;
      endcase
    end
  end

  // Input stage. The hip plus knee angle is formed here at full width.
  logic signed [16:0] ang_q [3];
  item_t              in_item_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0]          <= 17'(angle_abad_i);
      ang_q[1]          <= 17'(angle_hip_i);
      ang_q[2]          <= 17'(angle_hip_i) + 17'(angle_knee_i);
      in_item_q.leg     <= leg_index_i;
      in_item_q.rate[0] <= rate_abad_i;
      in_item_q.rate[1] <= rate_hip_i;
      in_item_q.rate[2] <= rate_knee_i;
    end
  end

  // Sine and cosine of abduction, hip and hip plus knee, one lane each.
  trig_t trig [3];

  for (genvar g = 0; g < 3; g++) begin : g_sc
    lfk_sincos u_sincos (
      .clk_i   (clk_i),
      .en_i    (adv),
      .angle_i (ang_q[g]),
      .trig_o  (trig[g])
    );
  end

  item_t pd_q [SC_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0] <= in_item_q;
      for (int i = 1; i < SC_LAT; i++) begin
        pd_q[i] <= pd_q[i - 1];
      end
    end
  end

  // Stage 1: link lengths times sines and cosines (Q45). The abduction offset
  // is positive for legs 1 and 2 only.
  logic signed [15:0] l1, l2, l3;
  logic signed [47:0] l2c2_q, l3c23_q, l2s2_q, l3s23_q, l1c1_q, l1s1_q;
  logic signed [31:0] s1_1_q, c1_1_q;
  item_t              sd1_q;

  always_comb begin
    l1 = (pd_q[SC_LAT - 1].leg == 2'd1 || pd_q[SC_LAT - 1].leg == 2'd2)
         ? $signed({1'b0, abad_q}) : -$signed({1'b0, abad_q});
    l2 = $signed({1'b0, hip_q});
    l3 = $signed({1'b0, knee_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l2c2_q  <= 48'(l2) * 48'(trig[1].c);
      l3c23_q <= 48'(l3) * 48'(trig[2].c);
      l2s2_q  <= 48'(l2) * 48'(trig[1].s);
      l3s23_q <= 48'(l3) * 48'(trig[2].s);
      l1c1_q  <= 48'(l1) * 48'(trig[0].c);
      l1s1_q  <= 48'(l1) * 48'(trig[0].s);
      s1_1_q  <= trig[0].s;
      c1_1_q  <= trig[0].c;
      sd1_q   <= pd_q[SC_LAT - 1];
    end
  end

  // Stage 2: sagittal sums and terms in Q30 metres.
  logic signed [33:0] a_q, b_q, cc_q, ts_q, lc_q, ls_q;
  logic signed [31:0] s1_2_q, c1_2_q;
  item_t              sd2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q    <= 34'(rnd_shr(80'(l2c2_q) + 80'(l3c23_q), 15));
      b_q    <= 34'(rnd_shr(80'(l2s2_q) + 80'(l3s23_q), 15));
      cc_q   <= 34'(rnd_shr(80'(l3c23_q), 15));
      ts_q   <= 34'(rnd_shr(80'(l3s23_q), 15));
      lc_q   <= 34'(rnd_shr(80'(l1c1_q), 15));
      ls_q   <= 34'(rnd_shr(80'(l1s1_q), 15));
      s1_2_q <= s1_1_q;
      c1_2_q <= c1_1_q;
      sd2_q  <= sd1_q;
    end
  end

  // Stage 3: abduction rotation products (Q60).
  logic signed [65:0] s1a_q, c1a_q, s1b_q, c1b_q, s1ts_q, c1ts_q;
  logic signed [33:0] a3_q, b3_q, cc3_q, lc3_q, ls3_q;
  item_t              sd3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1a_q  <= 66'(s1_2_q) * 66'(a_q);
      c1a_q  <= 66'(c1_2_q) * 66'(a_q);
      s1b_q  <= 66'(s1_2_q) * 66'(b_q);
      c1b_q  <= 66'(c1_2_q) * 66'(b_q);
      s1ts_q <= 66'(s1_2_q) * 66'(ts_q);
      c1ts_q <= 66'(c1_2_q) * 66'(ts_q);
      a3_q   <= a_q;
      b3_q   <= b_q;
      cc3_q  <= cc_q;
      lc3_q  <= lc_q;
      ls3_q  <= ls_q;
      sd3_q  <= sd2_q;
    end
  end

  // Stage 4: foot position and Jacobian in Q30 metres.
  logic signed [34:0] r_s1a, r_c1a, r_s1b, r_c1b, r_s1ts, r_c1ts;
  logic signed [34:0] pos4_d [3];
  logic signed [34:0] jac4_d [3][3];
  logic signed [34:0] pos4_q [3];
  logic signed [34:0] jac4_q [3][3];
  item_t              sd4_q;

  always_comb begin
    r_s1a  = 35'(rnd_shr(80'(s1a_q), 30));
    r_c1a  = 35'(rnd_shr(80'(c1a_q), 30));
    r_s1b  = 35'(rnd_shr(80'(s1b_q), 30));
    r_c1b  = 35'(rnd_shr(80'(c1b_q), 30));
    r_s1ts = 35'(rnd_shr(80'(s1ts_q), 30));
    r_c1ts = 35'(rnd_shr(80'(c1ts_q), 30));

    pos4_d[0] = 35'(b3_q);
    pos4_d[1] = 35'(lc3_q) + r_s1a;
    pos4_d[2] = 35'(ls3_q) - r_c1a;

    // The x row never depends on abduction.
    jac4_d[0][0] = '0;
    jac4_d[0][1] = 35'(a3_q);
    jac4_d[0][2] = 35'(cc3_q);
    jac4_d[1][0] = r_c1a - 35'(ls3_q);
    jac4_d[1][1] = -r_s1b;
    jac4_d[1][2] = -r_s1ts;
    jac4_d[2][0] = 35'(lc3_q) + r_s1a;
    jac4_d[2][1] = r_c1b;
    jac4_d[2][2] = r_c1ts;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos4_q <= pos4_d;
      jac4_q <= jac4_d;
      sd4_q  <= sd3_q;
    end
  end

  // Stage 5: Jacobian times joint rates (Q40), and output scaling of
  // position and Jacobian.
  logic signed [50:0] vp_q [3][3];
  logic signed [15:0] pos16_q [3];
  logic signed [15:0] jac16_q [3][3];
  logic [1:0]         leg5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        pos16_q[r] <= sat16(rnd_shr(80'(pos4_q[r]), 17));
        for (int c = 0; c < 3; c++) begin
          vp_q[r][c]    <= 51'(jac4_q[r][c]) * 51'($signed(sd4_q.rate[c]));
          jac16_q[r][c] <= sat16(rnd_shr(80'(jac4_q[r][c]), 17));
        end
      end
      leg5_q <= sd4_q.leg;
    end
  end

  // Stage 6: the output register holds all three rows of one item.
  logic signed [23:0] vel_q [3];
  logic signed [15:0] opos_q [3];
  logic signed [15:0] ojac_q [3][3];
  logic [1:0]         oleg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        vel_q[r] <= sat24(rnd_shr(80'(vp_q[r][0]) + 80'(vp_q[r][1]) + 80'(vp_q[r][2]), 30));
      end
      opos_q <= pos16_q;
      ojac_q <= jac16_q;
      oleg_q <= leg5_q;
    end
  end

  // Row select.
  always_comb begin
    unique case (row_q)
      AXIS_X: begin
        foot_position_o = opos_q[0];
        foot_velocity_o = vel_q[0];
        jac_wrt_abad_o  = ojac_q[0][0];
        jac_wrt_hip_o   = ojac_q[0][1];
        jac_wrt_knee_o  = ojac_q[0][2];
      end
      AXIS_Y: begin
        foot_position_o = opos_q[1];
        foot_velocity_o = vel_q[1];
        jac_wrt_abad_o  = ojac_q[1][0];
        jac_wrt_hip_o   = ojac_q[1][1];
        jac_wrt_knee_o  = ojac_q[1][2];
      end
      default: begin
        foot_position_o = opos_q[2];
        foot_velocity_o = vel_q[2];
        jac_wrt_abad_o  = ojac_q[2][0];
        jac_wrt_hip_o   = ojac_q[2][1];
        jac_wrt_knee_o  = ojac_q[2][2];
      end
    endcase
  end

  assign out_valid_o = out_v_q;
  assign leg_echo_o  = oleg_q;
  assign axis_row_o  = row_q;
  assign row_last_o  = (row_q == AXIS_Z);

  // A stalled row stays where it is.
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_q))
    else $error("row changed under stall");

  // A taken row that is not the last moves to the next row of the same item.
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && row_q != AXIS_Z
    |=> out_valid_o && row_q == $past(row_q) + 2'd1)
    else $error("row sequence broken");

  // After the last row the next item starts at row x.
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && row_q == AXIS_Z |=> row_q == AXIS_X)
    else $error("new item did not start at row x");

  // Intake only opens when the output stage can take a new item.
  a_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o || (row_q == AXIS_Z && !out_stall_i))
    else $error("intake open while rows are pending");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the leg forward kinematics and Jacobian block.
// Leg items go in through the valid/stall input port. A bit-exact predictor
// in this module turns each accepted item into three expected rows, one each
// for x, y and z, and queues them. A checker compares every accepted output
// row, field by field, with the oldest queued row. The link lengths are
// reprogrammed between phases, and only while the block is idle.
module tb_top;
  import lfk_pkg::*;

  // Q30 constants used by the sine and cosine series.
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  // Number of cycles after which a hung run is declared failed.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to wait for the pipeline to drain.
  localparam int DRAIN_CYCLES = 60;
  // This index is not in the register list, so the block must ignore a write to it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One expected output row.
  typedef struct {
    logic [1:0]         leg;
    axis_e              row;
    logic signed [15:0] pos;
    logic signed [23:0] vel;
    logic signed [15:0] jac_abad;
    logic signed [15:0] jac_hip;
    logic signed [15:0] jac_knee;
    logic               last;
  } foot_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [14:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         leg_index_i;
  logic signed [15:0] angle_abad_i;
  logic signed [15:0] angle_hip_i;
  logic signed [15:0] angle_knee_i;
  logic signed [15:0] rate_abad_i;
  logic signed [15:0] rate_hip_i;
  logic signed [15:0] rate_knee_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         leg_echo_o;
  logic [1:0]         axis_row_o;
  logic signed [15:0] foot_position_o;
  logic signed [23:0] foot_velocity_o;
  logic signed [15:0] jac_wrt_abad_o;
  logic signed [15:0] jac_wrt_hip_o;
  logic signed [15:0] jac_wrt_knee_o;
  logic               row_last_o;

  leg_forward_kinematics_jacobian dut (.*);

  // The bench's own copy of the link length registers.
  longint    abad_len;
  longint    hip_len;
  longint    knee_len;
  // Rows that the predictor has produced but that have not come out yet.
  foot_row_t foot_rows_q[$];
  int        mismatches;
  int        cycle_count;
  // Bookkeeping for the sender's bursts and gaps.
  int        burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The run is aborted if it takes far longer than the slowest correct run could.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor arithmetic
  // ---------------------------------------------------------------------

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Rounds to nearest, with ties going away from zero.
  function automatic longint rnd_shift(longint v, int n);
    longint unsigned half;
    half = 64'd1 << (n - 1);
    if (v >= 0) return longint'((unsigned'(v) + half) >> n);
    return -longint'((unsigned'(-v) + half) >> n);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // The angle is in 2^-13 rad and the sine and cosine are in Q30. The magnitude
  // is reduced by the nearest multiple of pi/2, and the remainder goes through
  // the Taylor series in Horner form.
  function automatic void sin_cos_q30(input longint ang, output longint s_o, output longint c_o);
    bit              neg;
    bit              rneg;
    longint unsigned m, k, x, x2, t;
    longint          r, sr, cr, s, c;
    neg  = ang < 0;
    m    = unsigned'(neg ? -ang : ang) << 17;
    k    = (m + HALF_PI / 2) / HALF_PI;
    r    = longint'(m) - longint'(k * HALF_PI);
    rneg = r < 0;
    x    = unsigned'(rneg ? -r : r);
    x2   = qmul(x, x);
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - qmul(x2, t) / 42;
    t  = Q30_ONE - qmul(x2, t) / 20;
    t  = Q30_ONE - qmul(x2, t) / 6;
    sr = longint'(qmul(x, t));
    if (rneg) sr = -sr;
    t  = Q30_ONE - x2 / 90;
    t  = Q30_ONE - qmul(x2, t) / 56;
    t  = Q30_ONE - qmul(x2, t) / 30;
    t  = Q30_ONE - qmul(x2, t) / 12;
    t  = Q30_ONE - qmul(x2, t) / 2;
    cr = longint'(t);
    case (k[1:0])
      2'd0: begin s = sr;  c = cr;  end
      2'd1: begin s = cr;  c = -sr; end
      2'd2: begin s = -sr; c = -cr; end
      default: begin s = -cr; c = sr; end
    endcase
    s_o = neg ? -s : s;
    c_o = c;
  endfunction

  // Works out the three rows of one leg and queues them. All intermediate
  // lengths are Q30 metres.
  task automatic predict_leg_rows(input logic [1:0] leg, input logic signed [15:0] q1,
                                  input logic signed [15:0] q2, input logic signed [15:0] q3,
                                  input logic signed [15:0] w1, input logic signed [15:0] w2,
                                  input logic signed [15:0] w3);
    longint    s1, c1, s2, c2, s23, c23;
    longint    l1, a, b, cc, ts, lc, ls, vel;
    longint    pos[3];
    longint    jac[3][3];
    longint    rate[3];
    foot_row_t fr;
    rate[0] = longint'(w1);
    rate[1] = longint'(w2);
    rate[2] = longint'(w3);
    // The abduction offset is positive on legs 1 and 2 and negative on legs 0 and 3.
    l1 = (leg == 2'd1 || leg == 2'd2) ? abad_len : -abad_len;
    sin_cos_q30(longint'(q1), s1, c1);
    sin_cos_q30(longint'(q2), s2, c2);
    // The hip plus knee sum is formed at full width, so it never wraps.
    sin_cos_q30(longint'(q2) + longint'(q3), s23, c23);
    a  = rnd_shift(hip_len * c2 + knee_len * c23, 15);
    b  = rnd_shift(hip_len * s2 + knee_len * s23, 15);
    cc = rnd_shift(knee_len * c23, 15);
    ts = rnd_shift(knee_len * s23, 15);
    lc = rnd_shift(l1 * c1, 15);
    ls = rnd_shift(l1 * s1, 15);
    pos[0] = b;
    pos[1] = lc + rnd_shift(s1 * a, 30);
    pos[2] = ls - rnd_shift(c1 * a, 30);
    // The x row never depends on the abduction angle.
    jac[0][0] = 0;
    jac[0][1] = a;
    jac[0][2] = cc;
    jac[1][0] = -ls + rnd_shift(c1 * a, 30);
    jac[1][1] = -rnd_shift(s1 * b, 30);
    jac[1][2] = -rnd_shift(s1 * ts, 30);
    jac[2][0] = lc + rnd_shift(s1 * a, 30);
    jac[2][1] = rnd_shift(c1 * b, 30);
    jac[2][2] = rnd_shift(c1 * ts, 30);
    for (int row = 0; row < 3; row++) begin
      vel = 0;
      for (int col = 0; col < 3; col++) vel += jac[row][col] * rate[col];
      fr.leg      = leg;
      fr.row      = axis_e'(row);
      fr.pos      = 16'(clamp(rnd_shift(pos[row], 17), -32768, 32767));
      fr.vel      = 24'(clamp(rnd_shift(vel, 30), -8388608, 8388607));
      fr.jac_abad = 16'(clamp(rnd_shift(jac[row][0], 17), -32768, 32767));
      fr.jac_hip  = 16'(clamp(rnd_shift(jac[row][1], 17), -32768, 32767));
      fr.jac_knee = 16'(clamp(rnd_shift(jac[row][2], 17), -32768, 32767));
      fr.last     = (row == 2);
      foot_rows_q.push_back(fr);
    end
  endtask

  // ---------------------------------------------------------------------
  // Checker and the receiver's stall pattern
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", field, got, want, cycle_count);
    mismatches++;
  endtask

  // An output row is taken at every edge where valid is high and stall is low.
  always @(posedge clk_i) begin
    foot_row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (foot_rows_q.size() == 0) begin
        report_mismatch("unexpected row", axis_row_o, -1);
      end else begin
        want = foot_rows_q.pop_front();
        if (leg_echo_o !== want.leg) report_mismatch("leg_echo", leg_echo_o, want.leg);
        if (axis_row_o !== want.row) report_mismatch("axis_row", axis_row_o, want.row);
        if (foot_position_o !== want.pos)
          report_mismatch("foot_position", foot_position_o, want.pos);
        if (foot_velocity_o !== want.vel)
          report_mismatch("foot_velocity", foot_velocity_o, want.vel);
        if (jac_wrt_abad_o !== want.jac_abad)
          report_mismatch("jac_wrt_abad", jac_wrt_abad_o, want.jac_abad);
        if (jac_wrt_hip_o !== want.jac_hip)
          report_mismatch("jac_wrt_hip", jac_wrt_hip_o, want.jac_hip);
        if (jac_wrt_knee_o !== want.jac_knee)
          report_mismatch("jac_wrt_knee", jac_wrt_knee_o, want.jac_knee);
        if (row_last_o !== want.last) report_mismatch("row_last", row_last_o, want.last);
      end
    end
  end

  // The stall mode is redrawn at random. The modes are no stall, random
  // stall on about half the cycles, and long stall windows that move against
  // the three-row rhythm of the block.
  int stall_mode;
  int stall_phase;
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    stall_phase <= (stall_phase + 1) % 11;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= (stall_phase < 5);
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------

  // Sends one leg item and waits until the block takes it. After that comes
  // a random gap, or none while a burst is still running.
  task automatic send_leg(input logic [1:0] leg, input logic [15:0] q1, input logic [15:0] q2,
                          input logic [15:0] q3, input logic [15:0] w1, input logic [15:0] w2,
                          input logic [15:0] w3);
    in_valid_i   <= 1'b1;
    leg_index_i  <= leg;
    angle_abad_i <= q1;
    angle_hip_i  <= q2;
    angle_knee_i <= q3;
    rate_abad_i  <= w1;
    rate_hip_i   <= w2;
    rate_knee_i  <= w3;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_leg_rows(leg, q1, q2, q3, w1, w2, w3);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Waits until every queued row has come out, plus a safety margin.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (foot_rows_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register. The write valid stays high afterwards, so that
  // writes can follow back to back; the caller drops it after the last one.
  task automatic write_length(input logic [1:0] idx, input logic [14:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ABAD: abad_len = longint'(value);
      REG_HIP:  hip_len  = longint'(value);
      REG_KNEE: knee_len = longint'(value);
      default: ;
    endcase
  endtask

  task automatic set_lengths(input logic [14:0] l1, input logic [14:0] l2,
                             input logic [14:0] l3);
    wait_drained();
    write_length(REG_ABAD, l1);
    write_length(REG_HIP, l2);
    write_length(REG_KNEE, l3);
    cfg_valid_i <= 1'b0;
  endtask

  // Random angle. Mostly it stays within plus or minus pi, and sometimes it
  // covers the full 16-bit range, which the block must also handle.
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  // Directed items: every leg, the extreme angles and rates, quadrant edges near pi/2, hip
  // plus knee sums far past the 16-bit range, extreme lengths and a write to an unused index.
  task automatic test_directed();
    send_leg(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_leg(2'd1, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_leg(2'd2, 16'd25736, 16'd25736, 16'd25736, 16'h8000, 16'h8000, 16'h8000);
    send_leg(2'd3, -16'sd25736, -16'sd25736, -16'sd25736, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_leg(2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_leg(2'd2, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_leg(2'd0, 16'd12868, -16'sd12868, 16'd6434, 16'd1024, -16'sd1024, 16'd512);
    send_leg(2'd3, 16'd12869, 16'd12867, -16'sd12869, 16'd1, 16'd1, 16'd1);
    send_leg(2'd1, 16'd6434, 16'd6433, 16'd6435, 16'h5555, 16'hAAAA, 16'h5555);
    send_leg(2'd2, -16'sd6434, -16'sd19302, 16'd19302, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_leg(2'd0, 16'd0, 16'd25736, -16'sd25736, 16'd0, 16'h7FFF, 16'h8000);
    send_leg(2'd3, 16'd1, -16'sd1, 16'd0, 16'h8000, 16'd0, 16'h7FFF);
    // Items for the extreme lengths, sent after reprogramming.
    set_lengths(15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_leg(2'd1, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_leg(2'd0, 16'd12868, 16'd12868, 16'd0, 16'h8000, 16'h8000, 16'h8000);
    send_leg(2'd2, 16'h8000, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_leg(2'd3, -16'sd6434, 16'd3000, -16'sd3000, 16'h8000, 16'h7FFF, 16'h8000);
    set_lengths(15'd0, 15'd0, 15'd0);
    send_leg(2'd1, 16'd5000, 16'd5000, 16'd5000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_leg(2'd2, -16'sd5000, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000);
    // A write to an index outside the register list must leave every length as it was.
    wait_drained();
    write_length(REG_UNUSED, 15'h1234);
    cfg_valid_i <= 1'b0;
    send_leg(2'd0, 16'd3333, -16'sd7777, 16'd2222, 16'd100, 16'd200, -16'sd300);
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      send_leg(2'($urandom), rand_angle(), rand_angle(), rand_angle(),
               16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_ABAD;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    leg_index_i  = '0;
    angle_abad_i = '0;
    angle_hip_i  = '0;
    angle_knee_i = '0;
    rate_abad_i  = '0;
    rate_hip_i   = '0;
    rate_knee_i  = '0;
    out_stall_i  = 1'b0;
    stall_mode   = 0;
    stall_phase  = 0;
    mismatches   = 0;
    burst_left   = 0;
    // These are the lengths that the block loads at reset.
    abad_len = 2032;
    hip_len  = 6849;
    knee_len = 6390;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset lengths come first, then several settings, the extremes among them.
    test_random(100);
    test_directed();
    set_lengths(15'd2032, 15'd6849, 15'd6390);
    test_random(40);
    set_lengths(15'h7FFF, 15'h7FFF, 15'h7FFF);
    test_random(40);
    set_lengths(15'd0, 15'h7FFF, 15'd0);
    test_random(20);
    set_lengths(15'($urandom), 15'($urandom), 15'($urandom));
    test_random(45);
    set_lengths(15'($urandom), 15'($urandom), 15'($urandom));
    test_random(45);

    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
